// ----- rtl/plm_vl_pkg.sv -----
// shared definitions for the van leer face reconstruction pipeline
// limiter mode codes and the saturation point of wide quotients; no dependencies
package plm_vl_pkg;

  typedef enum logic [1:0] {
    LIM_UNIFORM    = 2'd0,
    LIM_CORRECTED  = 2'd1,
    LIM_NONUNIFORM = 2'd2
  } lim_mode_e;

  // wide quotients saturate at 2**WIDE_CAP_BITS
  localparam int WIDE_CAP_BITS = 62;

endpackage

// ----- rtl/plm_vl_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// flags a quotient that does not fit in QUO_W bits; no package dependencies
module plm_vl_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int NE  = (NUM_W > QUO_W) ? NUM_W : QUO_W + 1;
  localparam int HW  = NE - QUO_W;
  localparam int CMW = (HW > DEN_W) ? HW : DEN_W;

  logic [NE-1:0]    num_e;
  logic [HW-1:0]    num_hi;

  logic [DEN_W-1:0] rem_d [QUO_W+1];
  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] lo_d  [QUO_W+1];
  logic [QUO_W-1:0] lo_q  [QUO_W+1];
  logic [QUO_W-1:0] quo_d [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [DEN_W-1:0] den_d [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W:0]   ovf_d;
  logic [QUO_W:0]   ovf_q;

  assign num_e  = NE'(num_i);
  assign num_hi = num_e[NE-1:QUO_W];

  always_comb begin
    logic [DEN_W:0] r2;
    logic           ge;
    // first stage: overflow check and initial partial remainder
    rem_d[0] = DEN_W'(num_hi);
    lo_d[0]  = num_e[QUO_W-1:0];
    quo_d[0] = '0;
    den_d[0] = den_i;
    ovf_d[0] = CMW'(num_hi) >= CMW'(den_i);
    for (int k = 1; k <= QUO_W; k++) begin
      r2       = {rem_q[k-1], lo_q[k-1][QUO_W-1]};
      ge       = r2 >= {1'b0, den_q[k-1]};
      rem_d[k] = ge ? DEN_W'(r2 - {1'b0, den_q[k-1]}) : DEN_W'(r2);
      lo_d[k]  = lo_q[k-1] << 1;
      quo_d[k] = {quo_q[k-1][QUO_W-2:0], ge};
      den_d[k] = den_q[k-1];
      ovf_d[k] = ovf_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QUO_W; k++) begin
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_d[k];
      end
      ovf_q <= ovf_d;
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// ----- rtl/plm_vl_mul.sv -----
// two-stage unsigned multiplier: two registered partial products, then the sum
// no package dependencies
module plm_vl_mul #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int HA = A_W / 2;
  localparam int HB = A_W - HA;
  localparam int PW = A_W + B_W;

  logic [HA+B_W-1:0] plo_q;
  logic [HB+B_W-1:0] phi_q;
  logic [PW-1:0]     p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= a_i[HA-1:0] * b_i;
      phi_q <= a_i[A_W-1:HA] * b_i;
      p_q   <= PW'(plo_q) + (PW'(phi_q) << HA);
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/plm_van_leer_face_reconstruct.sv -----
// throughput: one word per cycle while the output is not stalled, set by the
// bit-per-stage dividers in every level
// a stalled output word holds the whole pipeline; nothing is dropped or repeated
// reset: async active low, clears valid bits and sets limiter mode to uniform
// datapath registers are not reset
module plm_van_leer_face_reconstruct #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] value_prev_i,
  input  logic signed [DATA_WIDTH-1:0] value_center_i,
  input  logic signed [DATA_WIDTH-1:0] value_next_i,
  input  logic [DATA_WIDTH-2:0]        face_width_i,
  input  logic [DATA_WIDTH-2:0]        center_gap_fwd_i,
  input  logic [DATA_WIDTH-2:0]        center_gap_back_i,
  input  logic [DATA_WIDTH-2:0]        dist_to_upper_face_i,
  input  logic [DATA_WIDTH-2:0]        dist_from_lower_face_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] upper_face_value_o,
  output logic signed [DATA_WIDTH-1:0] lower_face_value_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_data_i
);

  localparam int W    = DATA_WIDTH;
  localparam int FR   = FRAC_BITS;
  localparam int GW   = W - 1;
  localparam int CW   = W + 3;
  localparam int CAPB = plm_vl_pkg::WIDE_CAP_BITS;
  localparam int MW   = CAPB + 1;
  localparam int QW1  = CW;
  localparam int QW2  = (CW + FR > CAPB) ? CAPB : CW + FR;
  localparam int RW2  = QW2 + 1;
  localparam int DW3  = RW2 + 2;
  localparam int NW3  = RW2 + CW + 1;
  localparam int XW   = MW + 2;
  localparam int N1   = 2 + QW1 + 1;
  localparam int N2   = 2 + QW2 + 1;
  localparam int N3   = 3;
  localparam int N4   = CAPB + 1;
  localparam int N5   = 2 + CAPB + 1;

  typedef struct packed {
    logic                pos;
    logic                act;
    logic signed [W-1:0] vc;
    logic [W-1:0]        a_mag;
    logic [W-1:0]        b_mag;
    logic [GW-1:0]       w;
    logic [GW-1:0]       gf;
    logic [GW-1:0]       gb;
    logic [GW-1:0]       du;
    logic [GW-1:0]       dd;
    logic [CW-1:0]       f_s;
    logic [CW-1:0]       b_s;
    logic [CW:0]         hsum;
    logic [RW2-1:0]      h;
    logic [DW3-1:0]      den;
  } side_t;

  logic       adv;
  logic [1:0] mode_q;
  logic       mode_corr;
  logic       mode_nonu;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign mode_corr  = mode_q == plm_vl_pkg::LIM_CORRECTED;
  assign mode_nonu  = mode_q == plm_vl_pkg::LIM_NONUNIFORM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= plm_vl_pkg::LIM_UNIFORM;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // ---------------- differences and sign
  logic [W:0] dl, dr;
  side_t      sa_d, sa_q;
  logic       sa_v_q;

  assign dl = {value_center_i[W-1], value_center_i} - {value_prev_i[W-1], value_prev_i};
  assign dr = {value_next_i[W-1], value_next_i} - {value_center_i[W-1], value_center_i};

  always_comb begin
    sa_d       = '0;
    sa_d.pos   = !dl[W] && (dl != '0);
    sa_d.act   = (dl != '0) && (dr != '0) && (dl[W] == dr[W]);
    sa_d.vc    = value_center_i;
    sa_d.a_mag = dl[W] ? W'(-dl) : W'(dl);
    sa_d.b_mag = dr[W] ? W'(-dr) : W'(dr);
    // zero length acts as one lsb
    sa_d.w     = (face_width_i == '0)           ? GW'(1) : face_width_i;
    sa_d.gf    = (center_gap_fwd_i == '0)       ? GW'(1) : center_gap_fwd_i;
    sa_d.gb    = (center_gap_back_i == '0)      ? GW'(1) : center_gap_back_i;
    sa_d.du    = (dist_to_upper_face_i == '0)   ? GW'(1) : dist_to_upper_face_i;
    sa_d.dd    = (dist_from_lower_face_i == '0) ? GW'(1) : dist_from_lower_face_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else if (adv) begin
      sa_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q <= sa_d;
    end
  end

  // ---------------- level 1: geometry-scaled differences
  side_t           seg1_q [N1];
  logic [N1-1:0]   seg1_v_q;
  logic [2*W-2:0]  bw_p, aw_p;
  logic [QW1-1:0]  f_quo, b_quo;
  logic            f_ovf, b_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg1_v_q <= '0;
    end else if (adv) begin
      seg1_v_q <= {seg1_v_q[N1-2:0], sa_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg1_q[0] <= sa_q;
      for (int i = 1; i < N1; i++) begin
        seg1_q[i] <= seg1_q[i-1];
      end
    end
  end

  plm_vl_mul #(.A_W(W), .B_W(GW)) u_mul_bw (
    .clk_i(clk_i), .en_i(adv), .a_i(sa_q.b_mag), .b_i(sa_q.w), .p_o(bw_p)
  );
  plm_vl_mul #(.A_W(W), .B_W(GW)) u_mul_aw (
    .clk_i(clk_i), .en_i(adv), .a_i(sa_q.a_mag), .b_i(sa_q.w), .p_o(aw_p)
  );
  plm_vl_div #(.NUM_W(2*W-1), .DEN_W(GW), .QUO_W(QW1)) u_div_f (
    .clk_i(clk_i), .en_i(adv), .num_i(bw_p), .den_i(seg1_q[1].gf),
    .quo_o(f_quo), .ovf_o(f_ovf)
  );
  plm_vl_div #(.NUM_W(2*W-1), .DEN_W(GW), .QUO_W(QW1)) u_div_b (
    .clk_i(clk_i), .en_i(adv), .num_i(aw_p), .den_i(seg1_q[1].gb),
    .quo_o(b_quo), .ovf_o(b_ovf)
  );

  side_t         s2_d;
  logic [CW-1:0] hx, hy;

  always_comb begin
    s2_d     = seg1_q[N1-1];
    s2_d.f_s = f_ovf ? '1 : f_quo;
    s2_d.b_s = b_ovf ? '1 : b_quo;
    if ((mode_corr || mode_nonu) && (s2_d.f_s == '0 || s2_d.b_s == '0)) begin
      s2_d.act = 1'b0;
    end
    hx        = mode_nonu ? s2_d.f_s : CW'(s2_d.a_mag);
    hy        = mode_nonu ? s2_d.b_s : CW'(s2_d.b_mag);
    s2_d.hsum = (CW+1)'(hx) + (CW+1)'(hy);
  end

  // ---------------- level 2: ratios, curvature terms and harmonic mean
  side_t          seg2_q [N2];
  logic [N2-1:0]  seg2_v_q;
  logic [2*CW-1:0] hp;
  logic [QW2-1:0] t_quo, u_quo, cf_quo, cb_quo, h_quo;
  logic           t_ovf, u_ovf, cf_ovf, cb_ovf, h_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg2_v_q <= '0;
    end else if (adv) begin
      seg2_v_q <= {seg2_v_q[N2-2:0], seg1_v_q[N1-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg2_q[0] <= s2_d;
      for (int i = 1; i < N2; i++) begin
        seg2_q[i] <= seg2_q[i-1];
      end
    end
  end

  plm_vl_mul #(.A_W(CW), .B_W(CW)) u_mul_h (
    .clk_i(clk_i), .en_i(adv), .a_i(hx), .b_i(hy), .p_o(hp)
  );
  plm_vl_div #(.NUM_W(CW+FR), .DEN_W(CW), .QUO_W(QW2)) u_div_t (
    .clk_i(clk_i), .en_i(adv), .num_i({seg2_q[1].b_s, {FR{1'b0}}}),
    .den_i(seg2_q[1].f_s), .quo_o(t_quo), .ovf_o(t_ovf)
  );
  plm_vl_div #(.NUM_W(CW+FR), .DEN_W(CW), .QUO_W(QW2)) u_div_u (
    .clk_i(clk_i), .en_i(adv), .num_i({seg2_q[1].f_s, {FR{1'b0}}}),
    .den_i(seg2_q[1].b_s), .quo_o(u_quo), .ovf_o(u_ovf)
  );
  plm_vl_div #(.NUM_W(GW+FR), .DEN_W(GW), .QUO_W(QW2)) u_div_cf (
    .clk_i(clk_i), .en_i(adv), .num_i({seg2_q[1].gf, {FR{1'b0}}}),
    .den_i(seg2_q[1].du), .quo_o(cf_quo), .ovf_o(cf_ovf)
  );
  plm_vl_div #(.NUM_W(GW+FR), .DEN_W(GW), .QUO_W(QW2)) u_div_cb (
    .clk_i(clk_i), .en_i(adv), .num_i({seg2_q[1].gb, {FR{1'b0}}}),
    .den_i(seg2_q[1].dd), .quo_o(cb_quo), .ovf_o(cb_ovf)
  );
  plm_vl_div #(.NUM_W(2*CW+1), .DEN_W(CW+1), .QUO_W(QW2)) u_div_h (
    .clk_i(clk_i), .en_i(adv), .num_i({hp, 1'b0}), .den_i(seg2_q[1].hsum),
    .quo_o(h_quo), .ovf_o(h_ovf)
  );

  side_t          s3_d;
  logic [RW2-1:0] t_v, u_v, cf_v, cb_v;
  logic [DW3-1:0] den_sum;

  always_comb begin
    t_v     = t_ovf  ? (RW2'(1) << QW2) : RW2'(t_quo);
    u_v     = u_ovf  ? (RW2'(1) << QW2) : RW2'(u_quo);
    cf_v    = cf_ovf ? (RW2'(1) << QW2) : RW2'(cf_quo);
    cb_v    = cb_ovf ? (RW2'(1) << QW2) : RW2'(cb_quo);
    den_sum = DW3'(t_v) + DW3'(u_v) + DW3'(cf_v) + DW3'(cb_v);
    s3_d    = seg2_q[N2-1];
    s3_d.h  = h_ovf ? (RW2'(1) << QW2) : RW2'(h_quo);
    // a denominator that is not above two falls back to one lsb
    s3_d.den = (den_sum > (DW3'(1) << (FR + 1))) ? den_sum - (DW3'(1) << (FR + 1))
                                                  : DW3'(1);
  end

  // ---------------- level 3: corrected slope, then the slope chosen by limiter mode
  side_t              seg3_q [N3];
  logic [N3-1:0]      seg3_v_q;
  logic [RW2+CW-1:0]  pcb, pcf;
  logic [NW3-1:0]     num3_q;
  logic [CAPB-1:0]    m_quo;
  logic               m_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg3_v_q <= '0;
    end else if (adv) begin
      seg3_v_q <= {seg3_v_q[N3-2:0], seg2_v_q[N2-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg3_q[0] <= s3_d;
      for (int i = 1; i < N3; i++) begin
        seg3_q[i] <= seg3_q[i-1];
      end
      num3_q <= NW3'(pcf) + NW3'(pcb);
    end
  end

  plm_vl_mul #(.A_W(RW2), .B_W(CW)) u_mul_cf (
    .clk_i(clk_i), .en_i(adv), .a_i(cf_v), .b_i(seg2_q[N2-1].b_s), .p_o(pcf)
  );
  plm_vl_mul #(.A_W(RW2), .B_W(CW)) u_mul_cb (
    .clk_i(clk_i), .en_i(adv), .a_i(cb_v), .b_i(seg2_q[N2-1].f_s), .p_o(pcb)
  );
  plm_vl_div #(.NUM_W(NW3), .DEN_W(DW3), .QUO_W(CAPB)) u_div_m (
    .clk_i(clk_i), .en_i(adv), .num_i(num3_q), .den_i(seg3_q[N3-1].den),
    .quo_o(m_quo), .ovf_o(m_ovf)
  );

  side_t         seg4_q [N4];
  logic [N4-1:0] seg4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg4_v_q <= '0;
    end else if (adv) begin
      seg4_v_q <= {seg4_v_q[N4-2:0], seg3_v_q[N3-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg4_q[0] <= seg3_q[N3-1];
      for (int i = 1; i < N4; i++) begin
        seg4_q[i] <= seg4_q[i-1];
      end
    end
  end

  logic [MW-1:0] slope;

  always_comb begin
    if (!seg4_q[N4-1].act) begin
      slope = '0;
    end else if (mode_corr) begin
      slope = m_ovf ? (MW'(1) << CAPB) : MW'(m_quo);
    end else begin
      slope = MW'(seg4_q[N4-1].h);
    end
  end

  // ---------------- level 4: face offsets
  side_t            seg5_q [N5];
  logic [N5-1:0]    seg5_v_q;
  logic [MW+GW-1:0] pu, pd;
  logic [CAPB-1:0]  qu_quo, qd_quo;
  logic             qu_ovf, qd_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg5_v_q <= '0;
    end else if (adv) begin
      seg5_v_q <= {seg5_v_q[N5-2:0], seg4_v_q[N4-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg5_q[0] <= seg4_q[N4-1];
      for (int i = 1; i < N5; i++) begin
        seg5_q[i] <= seg5_q[i-1];
      end
    end
  end

  plm_vl_mul #(.A_W(MW), .B_W(GW)) u_mul_qu (
    .clk_i(clk_i), .en_i(adv), .a_i(slope), .b_i(seg4_q[N4-1].du), .p_o(pu)
  );
  plm_vl_mul #(.A_W(MW), .B_W(GW)) u_mul_qd (
    .clk_i(clk_i), .en_i(adv), .a_i(slope), .b_i(seg4_q[N4-1].dd), .p_o(pd)
  );
  plm_vl_div #(.NUM_W(MW+GW), .DEN_W(GW), .QUO_W(CAPB)) u_div_qu (
    .clk_i(clk_i), .en_i(adv), .num_i(pu), .den_i(seg5_q[1].w),
    .quo_o(qu_quo), .ovf_o(qu_ovf)
  );
  plm_vl_div #(.NUM_W(MW+GW), .DEN_W(GW), .QUO_W(CAPB)) u_div_qd (
    .clk_i(clk_i), .en_i(adv), .num_i(pd), .den_i(seg5_q[1].w),
    .quo_o(qd_quo), .ovf_o(qd_ovf)
  );

  // ---------------- faces and saturation
  localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] MINV = ~MAXV;

  logic signed [XW-1:0] vce, que, qde, up_s, lo_s;
  logic signed [W-1:0]  up_d, lo_d;
  logic signed [W-1:0]  up_q, lo_q;
  logic                 out_v_q;

  always_comb begin
    vce  = XW'(seg5_q[N5-1].vc);
    que  = qu_ovf ? (XW'(1) << CAPB) : XW'(qu_quo);
    qde  = qd_ovf ? (XW'(1) << CAPB) : XW'(qd_quo);
    up_s = seg5_q[N5-1].pos ? vce + que : vce - que;
    lo_s = seg5_q[N5-1].pos ? vce - qde : vce + qde;
    if (up_s > MAXV) begin
      up_d = MAXV[W-1:0];
    end else if (up_s < MINV) begin
      up_d = MINV[W-1:0];
    end else begin
      up_d = up_s[W-1:0];
    end
    if (lo_s > MAXV) begin
      lo_d = MAXV[W-1:0];
    end else if (lo_s < MINV) begin
      lo_d = MINV[W-1:0];
    end else begin
      lo_d = lo_s[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= seg5_v_q[N5-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      up_q <= up_d;
      lo_q <= lo_d;
    end
  end

  assign out_valid_o        = out_v_q;
  assign upper_face_value_o = up_q;
  assign lower_face_value_o = lo_q;

endmodule
